// File: rtl/srtset_pkg.sv
// ----------------------------------------------------------------------------
// srtset_pkg: shared definitions for the sorted integer set
// Key type, operation codes, reserved keys, sizing and cell control.
// ----------------------------------------------------------------------------
package srtset_pkg;

  // sizing
  localparam int unsigned CAPACITY = 1024;
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);
  localparam int unsigned KEY_W    = 32;
  localparam int unsigned FUNC_W   = 2;

  // match reduction: first level groups, second level combines the groups
  localparam int unsigned OR_GRP   = 32;
  localparam int unsigned OR_NGRP  = (CAPACITY + OR_GRP - 1) / OR_GRP;

  // operation codes
  localparam logic [FUNC_W-1:0] FUNC_ADD    = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_REMOVE = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_QUERY  = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

  typedef logic signed [KEY_W-1:0] key_t;

  // reserved bound keys
  localparam key_t KEY_LOW_RESERVED  = 32'sh8000_0000;
  localparam key_t KEY_HIGH_RESERVED = 32'sh7FFF_FFFF;

  // control broadcast to every cell
  typedef struct packed {
    logic cmp;  // compare stored key against search key
    logic ins;  // shift up and insert
    logic del;  // shift down over the removed key
  } cell_ctrl_t;

endpackage

// File: rtl/srtset_cell.sv
// ----------------------------------------------------------------------------
// srtset_cell: one storage cell of the sorted chain
// Holds one key, compares it with the search key and shifts with neighbors.
// ----------------------------------------------------------------------------
module srtset_cell (
  input  logic                    clk_i,
  input  srtset_pkg::cell_ctrl_t  ctrl_i,
  input  logic                    occ_i,
  input  srtset_pkg::key_t        key_i,
  input  logic                    prev_lt_i,
  input  srtset_pkg::key_t        prev_key_i,
  input  srtset_pkg::key_t        next_key_i,
  output srtset_pkg::key_t        key_o,
  output logic                    lt_o,
  output logic                    eq_o
);
  import srtset_pkg::*;

  key_t key_q;
  logic lt_q;
  logic eq_q;

  // compare result, held until the shift is applied
  always_ff @(posedge clk_i) begin
    if (ctrl_i.cmp) begin
      lt_q <= occ_i && (key_q < key_i);
      eq_q <= occ_i && (key_q == key_i);
    end
  end

  // cells at or above the slot move up on insert, down on remove
  always_ff @(posedge clk_i) begin
    if (ctrl_i.ins && !lt_q) begin
      key_q <= prev_lt_i ? key_i : prev_key_i;
    end else if (ctrl_i.del && !lt_q) begin
      key_q <= next_key_i;
    end
  end

  assign key_o = key_q;
  assign lt_o  = lt_q;
  assign eq_o  = eq_q;

endmodule

// File: rtl/srtset_or_tree.sv
// ----------------------------------------------------------------------------
// srtset_or_tree: registered two-level match reduction
// Combines the per-cell match flags into one hit flag through two registered levels.
// ----------------------------------------------------------------------------
module srtset_or_tree (
  input  logic                               clk_i,
  input  logic [srtset_pkg::CAPACITY-1:0]    eq_i,
  output logic                               hit_o
);
  import srtset_pkg::*;

  logic [OR_NGRP*OR_GRP-1:0] pad;
  logic [OR_NGRP-1:0]        grp_d;
  logic [OR_NGRP-1:0]        grp_q;
  logic                      hit_q;

  // pad the flags to whole groups
  always_comb begin
    pad                 = '0;
    pad[CAPACITY-1:0]   = eq_i;
  end

  // first level: one OR per group
  for (genvar g = 0; g < OR_NGRP; g++) begin : g_grp
    assign grp_d[g] = |pad[g*OR_GRP +: OR_GRP];
  end

  // both levels registered
  always_ff @(posedge clk_i) begin
    grp_q <= grp_d;
    hit_q <= |grp_q;
  end

  assign hit_o = hit_q;

endmodule

// File: rtl/sorted_integer_set.sv
// ----------------------------------------------------------------------------
// sorted_integer_set: set of distinct signed keys kept in ascending order
// Chain of key cells with broadcast compare and neighbor shifting.
// ----------------------------------------------------------------------------
// Usage:
//   input channel  : in_valid_i / in_ready_o with func_i (add, remove, query)
//                    and key_i; one transaction per operation
//   output channel : out_valid_o / out_ready_i with success_o and set_full_o;
//                    exactly one result transaction per input transaction
//   result path    : the result is registered after the broadcast compare in
//                    every cell, the two registered levels of the match
//                    reduction and the shift step, once the output register is free
//   sequencing     : a new operation is accepted only after the previous one
//                    has left its shift step
//   stall          : a result not yet taken holds the output register; the
//                    next operation is accepted and then waits at its shift
//                    step until the output register frees up
//   reset          : rst_ni clears the key count, so the set starts empty;
//                    the cells themselves are not cleared
//   reserved keys  : the two extreme keys and func code 3 change nothing and
//                    report success 0, set_full 0
// ----------------------------------------------------------------------------
module sorted_integer_set (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [srtset_pkg::FUNC_W-1:0]       func_i,
  input  logic signed [srtset_pkg::KEY_W-1:0] key_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic                                success_o,
  output logic                                set_full_o
);
  import srtset_pkg::*;

  // sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_CMP  = 3'd1;
  localparam logic [2:0] S_RED1 = 3'd2;
  localparam logic [2:0] S_RED2 = 3'd3;
  localparam logic [2:0] S_DEC  = 3'd4;

  logic [2:0]        state_q, state_d;
  logic [FUNC_W-1:0] func_q;
  key_t              key_q;
  logic [CNT_W-1:0]  count_q, count_d;
  logic              out_valid_q;
  logic              success_q;
  logic              full_q;

  cell_ctrl_t        ctrl;
  logic [CAPACITY-1:0] lt_vec;
  logic [CAPACITY-1:0] eq_vec;
  key_t              cell_key [CAPACITY];
  logic              hit;

  logic in_fire;
  logic slot_free;
  logic load;
  logic op_ok;
  logic is_full;
  logic do_ins;
  logic do_del;
  logic res_success;
  logic res_full;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign slot_free  = !out_valid_q || out_ready_i;
  assign load       = (state_q == S_DEC) && slot_free;

  // decode of the operation once the hit flag is ready
  assign op_ok   = (func_q != FUNC_UNUSED) && (key_q != KEY_LOW_RESERVED) &&
                   (key_q != KEY_HIGH_RESERVED);
  assign is_full = (count_q == CNT_W'(CAPACITY));

  always_comb begin
    do_ins      = 1'b0;
    do_del      = 1'b0;
    res_success = 1'b0;
    res_full    = 1'b0;
    if (op_ok) begin
      unique case (func_q)
        FUNC_ADD: begin
          if (!hit) begin
            if (is_full) begin
              res_full = 1'b1;
            end else begin
              do_ins      = 1'b1;
              res_success = 1'b1;
            end
          end
        end
        FUNC_REMOVE: begin
          do_del      = hit;
          res_success = hit;
        end
        FUNC_QUERY: begin
          res_success = hit;
        end
        default: begin
          res_success = 1'b0;
        end
      endcase
    end
  end

  // cell control
  always_comb begin
    ctrl     = '0;
    ctrl.cmp = (state_q == S_CMP);
    ctrl.ins = load && do_ins;
    ctrl.del = load && do_del;
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (in_fire) state_d = S_CMP;
      S_CMP:   state_d = S_RED1;
      S_RED1:  state_d = S_RED2;
      S_RED2:  state_d = S_DEC;
      S_DEC:   if (slot_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // key count
  always_comb begin
    count_d = count_q;
    if (ctrl.ins) begin
      count_d = count_q + CNT_W'(1);
    end else if (ctrl.del) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // operation and result registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      func_q <= func_i;
      key_q  <= key_i;
    end
    if (load) begin
      success_q <= res_success;
      full_q    <= res_full;
    end
  end

  // chain of cells
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic occ;
    logic prev_lt;
    key_t prev_key;
    key_t next_key;

    assign occ = (CNT_W'(i) < count_q);

    if (i == 0) begin : g_first
      assign prev_lt  = 1'b1;
      assign prev_key = key_q;
    end else begin : g_mid
      assign prev_lt  = lt_vec[i-1];
      assign prev_key = cell_key[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign next_key = cell_key[i];
    end else begin : g_inner
      assign next_key = cell_key[i+1];
    end

    srtset_cell u_cell (
      .clk_i      (clk_i),
      .ctrl_i     (ctrl),
      .occ_i      (occ),
      .key_i      (key_q),
      .prev_lt_i  (prev_lt),
      .prev_key_i (prev_key),
      .next_key_i (next_key),
      .key_o      (cell_key[i]),
      .lt_o       (lt_vec[i]),
      .eq_o       (eq_vec[i])
    );
  end

  // match reduction
  srtset_or_tree u_or_tree (
    .clk_i (clk_i),
    .eq_i  (eq_vec),
    .hit_o (hit)
  );

  assign out_valid_o = out_valid_q;
  assign success_o   = success_q;
  assign set_full_o  = full_q;

  // count never passes the capacity
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(CAPACITY))
    else $error("key count above capacity");

  // keys are distinct, so at most one cell matches
  a_one_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RED1) |-> $onehot0(eq_vec))
    else $error("more than one cell matches the key");

  // an insert grows the set by one
  a_ins_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.ins |=> (count_q == $past(count_q) + CNT_W'(1)))
    else $error("insert did not grow the count");

  // a full report never comes with success
  a_full_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(success_o && set_full_o))
    else $error("success and full reported together");

endmodule

// File: tb/sv/sorted_integer_set_tb.sv
// ----------------------------------------------------------------------------
// sorted_integer_set_tb: self-checking testbench for the sorted integer set
// Sends add, remove and query transactions with bursty input and a stalling
// output side. Each result is checked against a shadow set kept here.
// ----------------------------------------------------------------------------
module sorted_integer_set_tb;
  import srtset_pkg::*;

  localparam key_t KEY_MIN_USABLE = KEY_LOW_RESERVED + 32'sd1;
  localparam key_t KEY_MAX_USABLE = KEY_HIGH_RESERVED - 32'sd1;
  localparam int   IDLE_LIMIT     = 2000;
  localparam int   SETTLE_CYCLES  = 10;

  // expected outcome of one operation, with its request for reporting
  typedef struct {
    logic [FUNC_W-1:0] op;
    key_t              key;
    logic              success;
    logic              set_full;
  } outcome_t;

  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              in_valid_i  = 1'b0;
  logic              in_ready_o;
  logic [FUNC_W-1:0] func_i      = FUNC_ADD;
  key_t              key_i       = '0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  logic              success_o;
  logic              set_full_o;

  // shadow of the set contents: membership lookup plus a list for picking
  bit       held_keys[int];
  key_t     held_list[$];
  outcome_t pending_outcomes[$];

  int err_cnt     = 0;
  int burst_left  = 0;
  int ready_hold  = 0;

  sorted_integer_set i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .func_i      (func_i),
    .key_i       (key_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .success_o   (success_o),
    .set_full_o  (set_full_o)
  );

  // clock
  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // apply one operation to the shadow set and return its outcome
  function automatic outcome_t apply_set_op(logic [FUNC_W-1:0] op, key_t k);
    outcome_t res;
    bit       present;
    int       found[$];
    res = '{op: op, key: k, success: 1'b0, set_full: 1'b0};
    if (op == FUNC_UNUSED || k == KEY_LOW_RESERVED || k == KEY_HIGH_RESERVED) begin
      return res;
    end
    present = held_keys.exists(int'(k));
    case (op)
      FUNC_ADD: begin
        if (!present) begin
          if (held_list.size() >= CAPACITY) begin
            res.set_full = 1'b1;
          end else begin
            held_keys[int'(k)] = 1'b1;
            held_list.push_back(k);
            res.success = 1'b1;
          end
        end
      end
      FUNC_REMOVE: begin
        if (present) begin
          held_keys.delete(int'(k));
          found = held_list.find_first_index(x) with (x == k);
          held_list.delete(found[0]);
          res.success = 1'b1;
        end
      end
      default: begin
        res.success = present;
      end
    endcase
    return res;
  endfunction

  // any key of the full range except the reserved bounds
  function automatic key_t any_key();
    key_t k;
    k = key_t'($urandom);
    if (k == KEY_LOW_RESERVED) k = KEY_MIN_USABLE;
    if (k == KEY_HIGH_RESERVED) k = KEY_MAX_USABLE;
    return k;
  endfunction

  // a usable key not currently held
  function automatic key_t fresh_key();
    key_t k;
    do k = any_key(); while (held_keys.exists(int'(k)));
    return k;
  endfunction

  function automatic key_t held_key();
    return held_list[$urandom_range(0, held_list.size() - 1)];
  endfunction

  // send one transaction, idling between bursts, and record its outcome
  task automatic send_op(input logic [FUNC_W-1:0] op, input key_t k);
    int gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if ($urandom_range(0, 3) != 0) gap = $urandom_range(1, 12);
    end
    burst_left--;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    func_i     <= op;
    key_i      <= k;
    do @(posedge clk_i); while (!in_ready_o);
    pending_outcomes.push_back(apply_set_op(op, k));
  endtask

  // extremes, reserved keys, duplicates, absent keys and the unused code
  task automatic test_directed();
    send_op(FUNC_QUERY, KEY_MIN_USABLE);
    send_op(FUNC_REMOVE, 32'sd5);
    send_op(FUNC_ADD, KEY_LOW_RESERVED);
    send_op(FUNC_ADD, KEY_HIGH_RESERVED);
    send_op(FUNC_REMOVE, KEY_LOW_RESERVED);
    send_op(FUNC_QUERY, KEY_HIGH_RESERVED);
    send_op(FUNC_ADD, KEY_MIN_USABLE);
    send_op(FUNC_ADD, KEY_MAX_USABLE);
    send_op(FUNC_ADD, 32'sd0);
    send_op(FUNC_ADD, -32'sd1);
    send_op(FUNC_ADD, 32'sd1);
    send_op(FUNC_ADD, 32'sd0);
    send_op(FUNC_QUERY, KEY_MIN_USABLE);
    send_op(FUNC_QUERY, KEY_MAX_USABLE);
    send_op(FUNC_QUERY, 32'sd2);
    send_op(FUNC_UNUSED, 32'sd0);
    send_op(FUNC_UNUSED, KEY_MAX_USABLE);
    send_op(FUNC_REMOVE, -32'sd1);
    send_op(FUNC_REMOVE, -32'sd1);
    send_op(FUNC_QUERY, -32'sd1);
    send_op(FUNC_QUERY, KEY_LOW_RESERVED);
    send_op(FUNC_REMOVE, KEY_HIGH_RESERVED);
    send_op(FUNC_ADD, 32'sh5555_5555);
    send_op(FUNC_ADD, key_t'(32'hAAAA_AAAB));
    send_op(FUNC_REMOVE, KEY_MIN_USABLE);
  endtask

  // random operations on a narrow key pool so that hits and misses both occur
  task automatic test_random_mix(input int n_ops);
    int                sel;
    logic [FUNC_W-1:0] op;
    key_t              k;
    for (int i = 0; i < n_ops; i++) begin
      sel = $urandom_range(0, 9);
      if (sel < 4)      op = FUNC_ADD;
      else if (sel < 7) op = FUNC_REMOVE;
      else if (sel < 9) op = FUNC_QUERY;
      else              op = FUNC_UNUSED;
      sel = $urandom_range(0, 19);
      if (sel < 14)      k = key_t'($urandom_range(0, 63)) - 32'sd32;
      else if (sel < 18) k = any_key();
      else if (sel < 19) k = ($urandom_range(0, 1) == 1) ? KEY_MIN_USABLE : KEY_MAX_USABLE;
      else               k = ($urandom_range(0, 1) == 1) ? KEY_LOW_RESERVED : KEY_HIGH_RESERVED;
      send_op(op, k);
    end
  endtask

  // add new keys until the set holds its capacity, with some lookups and duplicate adds between
  task automatic test_fill_to_capacity();
    while (held_list.size() < CAPACITY) begin
      case ($urandom_range(0, 19))
        0:       send_op(FUNC_QUERY, held_key());
        1:       send_op(FUNC_QUERY, fresh_key());
        2:       send_op(FUNC_ADD, held_key());
        default: send_op(FUNC_ADD, fresh_key());
      endcase
    end
  endtask

  // operations on a full set: failing adds, removals, refills, lookups and reserved or unused requests
  task automatic test_full_set(input int n_ops);
    for (int i = 0; i < n_ops; i++) begin
      case ($urandom_range(0, 7))
        0, 1, 2: send_op(FUNC_ADD, fresh_key());
        3:       send_op(FUNC_ADD, held_key());
        4:       send_op(FUNC_QUERY, held_key());
        5:       send_op(FUNC_REMOVE, held_key());
        6: begin
          if ($urandom_range(0, 1) == 1) send_op(FUNC_ADD, KEY_HIGH_RESERVED);
          else                           send_op(FUNC_UNUSED, fresh_key());
        end
        default: send_op(FUNC_QUERY, fresh_key());
      endcase
    end
  endtask

  // output stalls: long ready stretches, stall runs and random toggling
  always @(posedge clk_i) begin
    if (ready_hold > 0) begin
      ready_hold--;
    end else begin
      case ($urandom_range(0, 3))
        0: begin
          out_ready_i <= 1'b1;
          ready_hold  = $urandom_range(20, 60);
        end
        1: begin
          out_ready_i <= 1'b0;
          ready_hold  = $urandom_range(1, 15);
        end
        default: out_ready_i <= ($urandom_range(0, 1) == 1);
      endcase
    end
  end

  // compare each result transaction with the oldest pending outcome
  always @(posedge clk_i) begin : result_check
    outcome_t exp_res;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_outcomes.size() == 0) begin
        $display("%0t: unexpected result, actual success %0b set_full %0b",
                 $time, success_o, set_full_o);
        err_cnt++;
      end else begin
        exp_res = pending_outcomes.pop_front();
        if (success_o !== exp_res.success) begin
          $display("%0t: success mismatch (func %0d key %0d), expected %0b, actual %0b",
                   $time, exp_res.op, exp_res.key, exp_res.success, success_o);
          err_cnt++;
        end
        if (set_full_o !== exp_res.set_full) begin
          $display("%0t: set_full mismatch (func %0d key %0d), expected %0b, actual %0b",
                   $time, exp_res.op, exp_res.key, exp_res.set_full, set_full_o);
          err_cnt++;
        end
      end
    end
  end

  // watchdog on cycles without any transaction on either channel
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk_i);
      if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("simulation failed");
    $finish;
  end

  // test sequence
  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_random_mix(100);
    test_fill_to_capacity();
    test_full_set(80);
    in_valid_i <= 1'b0;

    // drain outstanding results, then give stray results time to show
    while (pending_outcomes.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    if (err_cnt == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/srtset_pkg.sv
rtl/srtset_cell.sv
rtl/srtset_or_tree.sv
rtl/sorted_integer_set.sv
tb/sv/sorted_integer_set_tb.sv
